// ----- rtl/core/packed_grey_pixel_writer_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the packed grey pixel writer
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PACKED_GREY_PIXEL_WRITER_CORE_ASSERT_SVH
`define PACKED_GREY_PIXEL_WRITER_CORE_ASSERT_SVH

// same-cycle implication
`define PGPW_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pgpw assertion failed");

// next-cycle implication
`define PGPW_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pgpw assertion failed");

`endif

// ----- rtl/core/pgpw_pkg.sv -----
// ----------------------------------------------------------------------------
// pgpw_pkg
// Shared widths, codes, defaults and types of the packed grey pixel writer.
// ----------------------------------------------------------------------------
package pgpw_pkg;

    localparam int OP_W       = 2;
    localparam int COORD_W    = 12;
    localparam int COLOUR_W   = 16;
    localparam int RAW_ADDR_W = 18;
    localparam int THRESH_W   = 9;
    localparam int BYTE_W     = 8;
    localparam int IDX_W      = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 16;

    localparam int DEF_PANEL_WIDTH  = 1024;
    localparam int DEF_PANEL_HEIGHT = 768;
    localparam int DEF_STORE_BYTES  = 196608;

    localparam logic [OP_W-1:0] OP_DRAW = 2'd0;
    localparam logic [OP_W-1:0] OP_FILL = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROTATION    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_DARK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_MID  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_LGT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DARK_COLOUR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LGT_COLOUR  = 3'd5;

    typedef struct packed {
        logic [1:0]          rotation;
        logic [THRESH_W-1:0] thresh_dark;
        logic [THRESH_W-1:0] thresh_mid;
        logic [THRESH_W-1:0] thresh_light;
        logic [COLOUR_W-1:0] dark_grey_colour;
        logic [COLOUR_W-1:0] light_grey_colour;
    } pgpw_cfg_t;

    localparam pgpw_cfg_t CFG_RESET = '{
        rotation:          2'd0,
        thresh_dark:       9'd192,
        thresh_mid:        9'd288,
        thresh_light:      9'd384,
        dark_grey_colour:  16'd31727,
        light_grey_colour: 16'd50712
    };

    typedef struct packed {
        logic       hit;
        logic [1:0] lane;
    } pgpw_loc_t;

endpackage

// ----- rtl/core/packed_grey_pixel_writer_core.sv -----
// ----------------------------------------------------------------------------
// packed_grey_pixel_writer_core
// 2-bit grey framebuffer writer with rotation, fill and byte read-back.
// ----------------------------------------------------------------------------
// One item is worked on at a time, and the store has a single read port and a
// single write port. A pixel draw and a byte read go from accept through map,
// read, merge/write and hand off before the next accept; an off-panel draw,
// an out-of-range read and op 3 skip the read and merge/write. A fill writes
// one byte per cycle. The result register lets a new item be accepted while
// the previous result still waits on m_axis_tready. The store holds no reset
// value: read only bytes that a draw or a fill has written.
// Configuration writes are always taken (cfg_ready is tied high).
// ----------------------------------------------------------------------------
module packed_grey_pixel_writer_core
    import pgpw_pkg::*;
#(
    parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT,
    parameter int STORE_BYTES  = DEF_STORE_BYTES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // op[1:0], pos_x[13:2], pos_y[25:14], colour[41:26], read_addr[59:42], zeros
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // read_data[7:0], written[8], zeros
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    `include "packed_grey_pixel_writer_core_assert.svh"

    localparam int ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PREP   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_MODIFY = 3'd3;
    localparam logic [2:0] ST_FILL   = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]                state_reg, state_next;
    pgpw_cfg_t                 cfg_reg;
    logic [ADDR_W-1:0]         fill_idx_reg, fill_idx_next;
    logic                      m_tvalid_reg, m_tvalid_next;

    logic [OP_W-1:0]           op_reg;
    logic signed [COORD_W-1:0] pos_x_reg;
    logic signed [COORD_W-1:0] pos_y_reg;
    logic [COLOUR_W-1:0]       colour_reg;
    logic [RAW_ADDR_W-1:0]     read_addr_reg;
    logic [ADDR_W-1:0]         addr_reg, addr_next;
    logic [1:0]                lane_reg, lane_next;
    logic [1:0]                code_reg, code_next;
    logic [BYTE_W-1:0]         res_data_reg, res_data_next;
    logic                      res_wr_reg, res_wr_next;
    logic [BYTE_W-1:0]         m_data_reg, m_data_next;
    logic                      m_wr_reg, m_wr_next;

    logic                      accept;
    pgpw_loc_t                 map_loc;
    logic [ADDR_W-1:0]         map_addr;
    logic [1:0]                grey_code;
    logic [IDX_W-1:0]          raw_addr_ext;
    logic                      raw_hit;
    logic                      rd_en;
    logic [BYTE_W-1:0]         rd_data;
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic [BYTE_W-1:0]         wr_data;
    logic [BYTE_W-1:0]         merged;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W-BYTE_W-1){1'b0}}, m_wr_reg, m_data_reg};

    pgpw_map #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .STORE_BYTES  (STORE_BYTES),
        .ADDR_W       (ADDR_W)
    ) u_map (
        .pos_x    (pos_x_reg),
        .pos_y    (pos_y_reg),
        .rotation (cfg_reg.rotation),
        .loc      (map_loc),
        .addr     (map_addr)
    );

    pgpw_grey u_grey (
        .colour (colour_reg),
        .cfg    (cfg_reg),
        .code   (grey_code)
    );

    pgpw_store #(
        .STORE_BYTES (STORE_BYTES),
        .ADDR_W      (ADDR_W)
    ) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign raw_addr_ext = IDX_W'(read_addr_reg);
    assign raw_hit      = raw_addr_ext < IDX_W'(STORE_BYTES);

    always_comb
    begin
        unique case (lane_reg)
            2'd0:    merged = {code_reg, rd_data[5:0]};
            2'd1:    merged = {rd_data[7:6], code_reg, rd_data[3:0]};
            2'd2:    merged = {rd_data[7:4], code_reg, rd_data[1:0]};
            default: merged = {rd_data[7:2], code_reg};
        endcase
    end

    assign rd_en   = (state_reg == ST_READ);
    assign wr_en   = (state_reg == ST_FILL) || ((state_reg == ST_MODIFY) && (op_reg == OP_DRAW));
    assign wr_addr = (state_reg == ST_FILL) ? fill_idx_reg : addr_reg;
    assign wr_data = (state_reg == ST_FILL) ? {4{code_reg}} : merged;

    always_comb
    begin
        state_next    = state_reg;
        fill_idx_next = fill_idx_reg;
        addr_next     = addr_reg;
        lane_next     = lane_reg;
        code_next     = code_reg;
        res_data_next = res_data_reg;
        res_wr_next   = res_wr_reg;
        m_tvalid_next = m_tvalid_reg && !m_axis_tready;
        m_data_next   = m_data_reg;
        m_wr_next     = m_wr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                code_next     = grey_code;
                res_data_next = '0;
                res_wr_next   = 1'b0;
                unique case (op_reg)
                    OP_DRAW:
                    begin
                        addr_next  = map_addr;
                        lane_next  = map_loc.lane;
                        state_next = map_loc.hit ? ST_READ : ST_DONE;
                    end
                    OP_FILL:
                    begin
                        state_next = ST_FILL;
                    end
                    OP_READ:
                    begin
                        addr_next  = raw_addr_ext[ADDR_W-1:0];
                        state_next = raw_hit ? ST_READ : ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_READ:
            begin
                state_next = ST_MODIFY;
            end
            ST_MODIFY:
            begin
                if (op_reg == OP_DRAW)
                begin
                    res_wr_next = 1'b1;
                end
                else
                begin
                    res_data_next = rd_data;
                end
                state_next = ST_DONE;
            end
            ST_FILL:
            begin
                if (fill_idx_reg == LAST_ADDR)
                begin
                    fill_idx_next = '0;
                    res_wr_next   = 1'b1;
                    state_next    = ST_DONE;
                end
                else
                begin
                    fill_idx_next = fill_idx_reg + ADDR_W'(1);
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_axis_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = res_data_reg;
                    m_wr_next     = res_wr_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_idx_reg <= '0;
            m_tvalid_reg <= 1'b0;
            cfg_reg      <= CFG_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            fill_idx_reg <= fill_idx_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_ROTATION:    cfg_reg.rotation          <= cfg_data[1:0];
                    REG_THRESH_DARK: cfg_reg.thresh_dark       <= cfg_data[THRESH_W-1:0];
                    REG_THRESH_MID:  cfg_reg.thresh_mid        <= cfg_data[THRESH_W-1:0];
                    REG_THRESH_LGT:  cfg_reg.thresh_light      <= cfg_data[THRESH_W-1:0];
                    REG_DARK_COLOUR: cfg_reg.dark_grey_colour  <= cfg_data;
                    REG_LGT_COLOUR:  cfg_reg.light_grey_colour <= cfg_data;
                    default:         cfg_reg                   <= cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= s_axis_tdata[1:0];
            pos_x_reg     <= s_axis_tdata[13:2];
            pos_y_reg     <= s_axis_tdata[25:14];
            colour_reg    <= s_axis_tdata[41:26];
            read_addr_reg <= s_axis_tdata[59:42];
        end
        addr_reg     <= addr_next;
        lane_reg     <= lane_next;
        code_reg     <= code_next;
        res_data_reg <= res_data_next;
        res_wr_reg   <= res_wr_next;
        m_data_reg   <= m_data_next;
        m_wr_reg     <= m_wr_next;
    end

    `PGPW_ASSERT_IMP(a_wr_only_in_write_states, wr_en,
        (state_reg == ST_MODIFY) || (state_reg == ST_FILL))
    `PGPW_ASSERT_NXT(a_accept_enters_prep, accept, state_reg == ST_PREP)
    `PGPW_ASSERT_IMP(a_fill_idx_idle_zero, state_reg != ST_FILL, fill_idx_reg == '0)
    `PGPW_ASSERT_NXT(a_done_loads_result,
        (state_reg == ST_DONE) && (!m_tvalid_reg || m_axis_tready),
        m_tvalid_reg && (state_reg == ST_IDLE))

endmodule

// ----- rtl/core/pgpw_store.sv -----
// ----------------------------------------------------------------------------
// pgpw_store
// Frame store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pgpw_store
    import pgpw_pkg::*;
#(
    parameter int STORE_BYTES = DEF_STORE_BYTES,
    parameter int ADDR_W      = RAW_ADDR_W
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [BYTE_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [BYTE_W-1:0] wr_data
);

    logic [BYTE_W-1:0] mem [STORE_BYTES];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/pgpw_grey.sv -----
// ----------------------------------------------------------------------------
// pgpw_grey
// RGB565 colour to 2-bit grey code: named colours first, then channel sum.
// ----------------------------------------------------------------------------
module pgpw_grey
    import pgpw_pkg::*;
(
    input  logic [COLOUR_W-1:0] colour,
    input  pgpw_cfg_t           cfg,
    output logic [1:0]          code
);

    logic [6:0]          sum;
    logic [THRESH_W-1:0] sum_ext;

    assign sum     = {2'b00, colour[15:11]} + {1'b0, colour[10:5]} + {2'b00, colour[4:0]};
    assign sum_ext = {2'b00, sum};

    always_comb
    begin
        priority if (colour == '0)
            code = 2'd0;
        else if (colour == '1)
            code = 2'd3;
        else if (colour == cfg.dark_grey_colour)
            code = 2'd1;
        else if (colour == cfg.light_grey_colour)
            code = 2'd2;
        else if (sum_ext < cfg.thresh_dark)
            code = 2'd0;
        else if (sum_ext < cfg.thresh_mid)
            code = 2'd1;
        else if (sum_ext < cfg.thresh_light)
            code = 2'd2;
        else
            code = 2'd3;
    end

endmodule

// ----- rtl/core/pgpw_map.sv -----
// ----------------------------------------------------------------------------
// pgpw_map
// Logical pixel to store byte: bounds check, rotation remap, byte address.
// ----------------------------------------------------------------------------
module pgpw_map
    import pgpw_pkg::*;
#(
    parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT,
    parameter int STORE_BYTES  = DEF_STORE_BYTES,
    parameter int ADDR_W       = RAW_ADDR_W
)
(
    input  logic signed [COORD_W-1:0] pos_x,
    input  logic signed [COORD_W-1:0] pos_y,
    input  logic [1:0]                rotation,
    output pgpw_loc_t                 loc,
    output logic [ADDR_W-1:0]         addr
);

    localparam logic [COORD_W:0] WIDTH_C  = (COORD_W+1)'(PANEL_WIDTH);
    localparam logic [COORD_W:0] HEIGHT_C = (COORD_W+1)'(PANEL_HEIGHT);
    localparam logic [COORD_W:0] WM1      = (COORD_W+1)'(PANEL_WIDTH - 1);
    localparam logic [COORD_W:0] HM1      = (COORD_W+1)'(PANEL_HEIGHT - 1);

    logic [COORD_W:0]   x_ext;
    logic [COORD_W:0]   y_ext;
    logic [COORD_W:0]   lw;
    logic [COORD_W:0]   lh;
    logic               in_bounds;
    logic [COORD_W:0]   wm1_x;
    logic [COORD_W:0]   wm1_y;
    logic [COORD_W:0]   hm1_x;
    logic [COORD_W:0]   hm1_y;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [IDX_W-1:0]   row_prod;
    logic [IDX_W-1:0]   idx;

    assign x_ext = {1'b0, pos_x};
    assign y_ext = {1'b0, pos_y};
    assign lw    = rotation[0] ? HEIGHT_C : WIDTH_C;
    assign lh    = rotation[0] ? WIDTH_C : HEIGHT_C;

    assign in_bounds = !pos_x[COORD_W-1] && !pos_y[COORD_W-1] && (x_ext < lw) && (y_ext < lh);

    assign wm1_x = WM1 - x_ext;
    assign wm1_y = WM1 - y_ext;
    assign hm1_x = HM1 - x_ext;
    assign hm1_y = HM1 - y_ext;

    always_comb
    begin
        unique case (rotation)
            2'd0:
            begin
                px = pos_x;
                py = pos_y;
            end
            2'd1:
            begin
                px = wm1_y[COORD_W-1:0];
                py = pos_x;
            end
            2'd2:
            begin
                px = wm1_x[COORD_W-1:0];
                py = hm1_y[COORD_W-1:0];
            end
            default:
            begin
                px = pos_y;
                py = hm1_x[COORD_W-1:0];
            end
        endcase
    end

    assign row_prod = IDX_W'(py) * IDX_W'(PANEL_WIDTH);
    assign idx      = IDX_W'(px[COORD_W-1:2]) + (row_prod >> 2);

    assign loc.hit  = in_bounds && (idx < IDX_W'(STORE_BYTES));
    assign loc.lane = px[1:0];
    assign addr     = idx[ADDR_W-1:0];

endmodule

// ----- tb/packed_grey_pixel_writer_core_tb.sv -----
// ----------------------------------------------------------------------------
// packed_grey_pixel_writer_core_tb
// Drives draw, fill, read and unused-op items into the grey framebuffer
// writer under random sender gaps and receiver stalls, and checks each result
// against a table entry or a local model of rotation, grey grading and store.
// ----------------------------------------------------------------------------
module packed_grey_pixel_writer_core_tb;
    import pgpw_pkg::*;

    localparam int PANEL_W      = DEF_PANEL_WIDTH;
    localparam int PANEL_H      = DEF_PANEL_HEIGHT;
    localparam int STORE_N      = DEF_STORE_BYTES;
    localparam int PHASE_ITEMS  = 130;
    localparam int DIR_N        = 26;
    localparam int CYCLE_LIMIT  = 5_000_000;

    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]              op;
        logic signed [COORD_W-1:0]    x;
        logic signed [COORD_W-1:0]    y;
        logic [COLOUR_W-1:0]          colour;
        logic [RAW_ADDR_W-1:0]        addr;
    } pix_cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rd;
        logic              wr;
    } pix_result_t;

    typedef struct packed {
        logic [OP_W-1:0]              op;
        logic signed [COORD_W-1:0]    x;
        logic signed [COORD_W-1:0]    y;
        logic [COLOUR_W-1:0]          colour;
        logic [RAW_ADDR_W-1:0]        addr;
        logic                         typed;
        logic [BYTE_W-1:0]            rd;
        logic                         wr;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pgpw_cfg_t         cfg_m;
    logic [BYTE_W-1:0] frame_bytes [int];
    logic [BYTE_W-1:0] fill_byte;
    int                drawn_addr [$];
    pix_result_t       pending_results [$];
    pix_result_t       got_result;
    int                mismatches;
    int                cycles;
    int                burst_left;
    int                rdy_mode;
    int                rdy_left;

    dir_row_t dir_table [DIR_N] = '{
        '{OP_NONE, 2047,  -1,    16'hFFFF, 18'h3FFFF, 1'b1, 8'h00, 1'b0},
        '{OP_DRAW, -1,    0,     16'h0000, 18'd0,     1'b1, 8'h00, 1'b0},
        '{OP_DRAW, 1024,  0,     16'h0000, 18'd0,     1'b1, 8'h00, 1'b0},
        '{OP_DRAW, 0,     768,   16'h0000, 18'd0,     1'b1, 8'h00, 1'b0},
        '{OP_DRAW, -2048, 2047,  16'hFFFF, 18'd0,     1'b1, 8'h00, 1'b0},
        '{OP_DRAW, 2047,  -2048, 16'hFFFF, 18'd0,     1'b1, 8'h00, 1'b0},
        '{OP_READ, 0,     0,     16'h0000, 18'd196608, 1'b1, 8'h00, 1'b0},
        '{OP_READ, 0,     0,     16'h0000, 18'h3FFFF, 1'b1, 8'h00, 1'b0},
        '{OP_FILL, 0,     0,     16'hFFFF, 18'd0,     1'b1, 8'h00, 1'b1},
        '{OP_READ, 0,     0,     16'h0000, 18'd0,     1'b1, 8'hFF, 1'b0},
        '{OP_READ, 0,     0,     16'h0000, 18'd196607, 1'b1, 8'hFF, 1'b0},
        '{OP_DRAW, 0,     0,     16'h0000, 18'd0,     1'b1, 8'h00, 1'b1},
        '{OP_READ, 0,     0,     16'h0000, 18'd0,     1'b1, 8'h3F, 1'b0},
        '{OP_DRAW, 1023,  767,   16'd31727, 18'd0,    1'b1, 8'h00, 1'b1},
        '{OP_READ, 0,     0,     16'h0000, 18'd196607, 1'b1, 8'hFD, 1'b0},
        '{OP_DRAW, 1,     0,     16'd50712, 18'd0,    1'b1, 8'h00, 1'b1},
        '{OP_READ, 0,     0,     16'h0000, 18'd0,     1'b1, 8'h2F, 1'b0},
        '{OP_DRAW, 2,     0,     16'h8410, 18'd0,     1'b0, 8'h00, 1'b0},
        '{OP_DRAW, 3,     0,     16'hFFFE, 18'd0,     1'b0, 8'h00, 1'b0},
        '{OP_READ, 0,     0,     16'h0000, 18'd0,     1'b0, 8'h00, 1'b0},
        '{OP_DRAW, 512,   384,   16'h0001, 18'd0,     1'b0, 8'h00, 1'b0},
        '{OP_READ, 0,     0,     16'h0000, 18'd98432, 1'b0, 8'h00, 1'b0},
        '{OP_DRAW, 1023,  0,     16'hF800, 18'd0,     1'b0, 8'h00, 1'b0},
        '{OP_READ, 0,     0,     16'h0000, 18'd255,   1'b0, 8'h00, 1'b0},
        '{OP_FILL, 0,     0,     16'h0000, 18'd0,     1'b1, 8'h00, 1'b1},
        '{OP_READ, 0,     0,     16'h0000, 18'd12345, 1'b1, 8'h00, 1'b0}
    };

    pgpw_cfg_t phase_cfg [1:4] = '{
        '{2'd1, 9'd40,  9'd80,  9'd110, 16'h1234, 16'hBEEF},
        '{2'd2, 9'd0,   9'd0,   9'd0,   16'h0000, 16'hFFFF},
        '{2'd3, 9'd511, 9'd511, 9'd511, 16'hFFFF, 16'h0000},
        '{2'd0, 9'd100, 9'd50,  9'd20,  16'h7BEF, 16'hC618}
    };

    packed_grey_pixel_writer_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [1:0] grey_level(input logic [COLOUR_W-1:0] c);
        int s;
        if (c == 16'h0000) return 2'd0;
        if (c == 16'hFFFF) return 2'd3;
        if (c == cfg_m.dark_grey_colour) return 2'd1;
        if (c == cfg_m.light_grey_colour) return 2'd2;
        s = int'((c & 16'hF800) >> 11) + int'((c & 16'h07E0) >> 5) + int'(c & 16'h001F);
        if (s < int'(cfg_m.thresh_dark)) return 2'd0;
        if (s < int'(cfg_m.thresh_mid)) return 2'd1;
        if (s < int'(cfg_m.thresh_light)) return 2'd2;
        return 2'd3;
    endfunction

    function automatic logic [BYTE_W-1:0] stored_byte(input int idx);
        return frame_bytes.exists(idx) ? frame_bytes[idx] : fill_byte;
    endfunction

    task automatic frame_step(input pix_cmd_t c, output pix_result_t r);
        int                x;
        int                y;
        int                lw;
        int                lh;
        int                px;
        int                py;
        int                idx;
        int                sh;
        logic [BYTE_W-1:0] g8;
        r = '0;
        case (c.op)
            OP_DRAW:
            begin
                x  = c.x;
                y  = c.y;
                lw = cfg_m.rotation[0] ? PANEL_H : PANEL_W;
                lh = cfg_m.rotation[0] ? PANEL_W : PANEL_H;
                if (x >= 0 && x < lw && y >= 0 && y < lh)
                begin
                    case (cfg_m.rotation)
                        2'd1:    begin px = PANEL_W - y - 1; py = x;               end
                        2'd2:    begin px = PANEL_W - x - 1; py = PANEL_H - y - 1; end
                        2'd3:    begin px = y;               py = PANEL_H - x - 1; end
                        default: begin px = x;               py = y;               end
                    endcase
                    idx = px / 4 + (py * PANEL_W) / 4;
                    if (idx < STORE_N)
                    begin
                        sh = 2 * (3 - (px % 4));
                        g8 = {6'b0, grey_level(c.colour)};
                        frame_bytes[idx] = (stored_byte(idx) & ~(8'h03 << sh)) | (g8 << sh);
                        drawn_addr.push_back(idx);
                        if (drawn_addr.size() > 16) void'(drawn_addr.pop_front());
                        r.wr = 1'b1;
                    end
                end
            end
            OP_FILL:
            begin
                fill_byte = {4{grey_level(c.colour)}};
                frame_bytes.delete();
                drawn_addr.delete();
                r.wr = 1'b1;
            end
            OP_READ:
            begin
                if (c.addr < STORE_N) r.rd = stored_byte(int'(c.addr));
            end
            default: ;
        endcase
    endtask

    function automatic logic [COLOUR_W-1:0] pick_colour();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return cfg_m.dark_grey_colour;
            3:       return cfg_m.light_grey_colour;
            default: return COLOUR_W'($urandom);
        endcase
    endfunction

    function automatic int pick_coord(input int span);
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return span - 1;
            default: return $urandom_range(0, span - 1);
        endcase
    endfunction

    function automatic pix_cmd_t random_cmd();
        pix_cmd_t c;
        int       pick;
        int       lw;
        int       lh;
        c.x      = COORD_W'($urandom);
        c.y      = COORD_W'($urandom);
        c.colour = pick_colour();
        c.addr   = RAW_ADDR_W'($urandom);
        lw       = cfg_m.rotation[0] ? PANEL_H : PANEL_W;
        lh       = cfg_m.rotation[0] ? PANEL_W : PANEL_H;
        pick     = $urandom_range(0, 99);
        if (pick < 50)
        begin
            c.op = OP_DRAW;
            c.x  = COORD_W'(pick_coord(lw));
            c.y  = COORD_W'(pick_coord(lh));
        end
        else if (pick < 60)
        begin
            c.op = OP_DRAW;
        end
        else if (pick < 94)
        begin
            c.op = OP_READ;
            pick = $urandom_range(0, 9);
            if (pick < 6 && drawn_addr.size() > 0)
                c.addr = RAW_ADDR_W'(drawn_addr[$urandom_range(0, drawn_addr.size() - 1)]);
            else if (pick < 9)
                c.addr = RAW_ADDR_W'($urandom_range(0, STORE_N - 1));
            else
                c.addr = RAW_ADDR_W'($urandom_range(STORE_N, (1 << RAW_ADDR_W) - 1));
        end
        else
        begin
            c.op = OP_NONE;
        end
        return c;
    endfunction

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected %0h, got %0h", what, want, got);
    endtask

    task automatic send_cmd(input pix_cmd_t c, input logic typed, input pix_result_t typed_res);
        pix_result_t r;
        int          gap;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, c.addr, c.colour, c.y, c.x, c.op};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        frame_step(c, r);
        pending_results.push_back(typed ? typed_res : r);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_ROTATION:    cfg_m.rotation          = val[1:0];
            REG_THRESH_DARK: cfg_m.thresh_dark       = val[THRESH_W-1:0];
            REG_THRESH_MID:  cfg_m.thresh_mid        = val[THRESH_W-1:0];
            REG_THRESH_LGT:  cfg_m.thresh_light      = val[THRESH_W-1:0];
            REG_DARK_COLOUR: cfg_m.dark_grey_colour  = val;
            REG_LGT_COLOUR:  cfg_m.light_grey_colour = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_cfg(input pgpw_cfg_t c);
        write_reg(REG_ROTATION,    CFG_DATA_W'(c.rotation));
        write_reg(REG_THRESH_DARK, CFG_DATA_W'(c.thresh_dark));
        write_reg(REG_THRESH_MID,  CFG_DATA_W'(c.thresh_mid));
        write_reg(REG_THRESH_LGT,  CFG_DATA_W'(c.thresh_light));
        write_reg(REG_DARK_COLOUR, c.dark_grey_colour);
        write_reg(REG_LGT_COLOUR,  c.light_grey_colour);
    endtask

    always @(negedge clk)
    begin
        if (rdy_left == 0)
        begin
            rdy_mode = $urandom_range(0, 3);
            rdy_left = (rdy_mode == 3) ? $urandom_range(1, 8) : $urandom_range(4, 40);
        end
        else
        begin
            rdy_left--;
        end
        m_axis_tready <= (rdy_mode == 2) ? 1'($urandom_range(0, 1)) : (rdy_mode != 3);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                note_mismatch("result with no item pending", 0, m_axis_tdata);
            end
            else
            begin
                got_result = pending_results.pop_front();
                if (m_axis_tdata[7:0] != got_result.rd)
                    note_mismatch("read_data", got_result.rd, m_axis_tdata[7:0]);
                if (m_axis_tdata[8] != got_result.wr)
                    note_mismatch("written", got_result.wr, m_axis_tdata[8]);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("packed_grey_pixel_writer_core_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        pix_cmd_t    c;
        pix_result_t tr;
        pgpw_cfg_t   rc;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        cfg_m         = CFG_RESET;
        fill_byte     = '0;
        mismatches    = 0;
        cycles        = 0;
        burst_left    = 0;
        rdy_mode      = 0;
        rdy_left      = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIR_N; i++)
        begin
            c  = '{dir_table[i].op, dir_table[i].x, dir_table[i].y,
                   dir_table[i].colour, dir_table[i].addr};
            tr = '{dir_table[i].rd, dir_table[i].wr};
            send_cmd(c, dir_table[i].typed, tr);
        end
        drain();

        for (int phase = 0; phase <= 5; phase++)
        begin
            if (phase >= 1 && phase <= 4)
            begin
                load_cfg(phase_cfg[phase]);
            end
            else if (phase == 5)
            begin
                rc.rotation          = 2'($urandom);
                rc.thresh_dark       = THRESH_W'($urandom_range(0, 140));
                rc.thresh_mid        = THRESH_W'($urandom_range(0, 140));
                rc.thresh_light      = THRESH_W'($urandom_range(0, 140));
                rc.dark_grey_colour  = COLOUR_W'($urandom);
                rc.light_grey_colour = COLOUR_W'($urandom);
                load_cfg(rc);
            end
            if (phase == 2 || phase == 4)
            begin
                c        = random_cmd();
                c.op     = OP_FILL;
                send_cmd(c, 1'b0, '0);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_cmd(random_cmd(), 1'b0, '0);
            drain();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("packed_grey_pixel_writer_core_tb: done, clean");
        else
            $display("packed_grey_pixel_writer_core_tb: done, errors");
        $finish;
    end

endmodule
